### rtl/lva_pkg.sv
// Shared types and constants for the least-used vector allocator.
// Holds field widths, status codes and the action codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lva_pkg;

	localparam int BASE_W   = 7;
	localparam int VEC_W    = 8;
	localparam int CNT_W    = 8;
	localparam int STATUS_W = 2;

	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [VEC_W-1:0]    vec_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [BASE_W-1:0]   base_t;

	localparam status_t ST_ALLOCATED = 2'd0;
	localparam status_t ST_FREED     = 2'd1;
	localparam status_t ST_IGNORED   = 2'd2;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam cnt_t  COUNT_MAX  = 8'hff;
	localparam base_t BASE_RESET = 7'd32;

endpackage

`default_nettype wire

### rtl/lva_count_mem.sv
// Usage count memory: synchronous RAM, separate read/write ports, registered read.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on lva_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lva_count_mem #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             rd_en,
	input  wire  [AW-1:0]   rd_addr,
	input  wire             wr_en,
	input  wire  [AW-1:0]   wr_addr,
	input  lva_pkg::cnt_t   wr_data,
	output lva_pkg::cnt_t   rd_data
);
	import lva_pkg::*;

	cnt_t             mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	cnt_t             rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### rtl/lva_seq.sv
// Sequencer: circular least-count scan, free lookup, read-modify-write of counts,
// base register, start position and output register.
// Depends on lva_pkg; drives the read and write ports of lva_count_mem.
`timescale 1ns / 1ps
`default_nettype none

module lva_seq #(
	parameter int VECTOR_COUNT = 128,
	parameter int SW           = 7
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_wr_en,
	input  lva_pkg::base_t     cfg_wr_data,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire                action,
	input  lva_pkg::vec_t      vector,
	output logic               out_valid,
	input  wire                out_stall,
	output lva_pkg::status_t   status,
	output lva_pkg::vec_t      vector_res,
	output lva_pkg::cnt_t      use_count,
	output logic               mem_rd_en,
	output logic [SW-1:0]      mem_rd_addr,
	output logic               mem_wr_en,
	output logic [SW-1:0]      mem_wr_addr,
	output lva_pkg::cnt_t      mem_wr_data,
	input  lva_pkg::cnt_t      mem_rd_data
);
	import lva_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ALLOC  = 3'd1;
	localparam logic [2:0] S_ADRAIN = 3'd2;
	localparam logic [2:0] S_AWRITE = 3'd3;
	localparam logic [2:0] S_FREAD  = 3'd4;
	localparam logic [2:0] S_FWRITE = 3'd5;

	localparam logic [SW-1:0] LAST_SLOT = SW'(VECTOR_COUNT - 1);
	localparam logic [VEC_W:0] SLOT_LIMIT = (VEC_W + 1)'(VECTOR_COUNT);

	logic [2:0]    state_q;
	logic [2:0]    state_d;
	base_t         base_q;
	logic [SW-1:0] start_q;
	logic [SW-1:0] addr_q;
	logic [SW-1:0] cnt_q;
	logic [SW-1:0] best_q;
	cnt_t          best_cnt_q;
	vec_t          vector_q;
	logic [SW-1:0] slot_q;
	logic          range_q;
	logic          scan_s1;
	logic          first_s1;
	logic [SW-1:0] slot_s1;
	logic          out_valid_q;
	status_t       status_q;
	vec_t          vector_res_q;
	cnt_t          use_count_q;

	logic          accept;
	logic          out_free;
	logic          commit;
	vec_t          free_slot;
	logic          free_in_range;
	logic [SW-1:0] addr_next;
	logic [SW-1:0] best_next;
	cnt_t          alloc_cnt;
	logic          free_hit;
	status_t       res_status;
	vec_t          res_vector;
	cnt_t          res_count;

	assign in_stall      = (state_q != S_IDLE);
	assign accept        = in_valid && !in_stall;
	assign out_free      = !out_valid_q || !out_stall;
	assign free_slot     = vector - {1'b0, base_q};
	assign free_in_range = ({1'b0, free_slot} < SLOT_LIMIT);
	assign addr_next     = (addr_q == LAST_SLOT) ? '0 : addr_q + SW'(1);
	assign best_next     = (best_q == LAST_SLOT) ? '0 : best_q + SW'(1);
	assign alloc_cnt     = (best_cnt_q == COUNT_MAX) ? best_cnt_q : best_cnt_q + CNT_W'(1);
	assign free_hit      = range_q && (mem_rd_data != '0);
	assign commit        = out_free && ((state_q == S_AWRITE) || (state_q == S_FWRITE));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (action == ACT_ALLOC) ? S_ALLOC : S_FREAD;
				end
			end
			S_ALLOC: begin
				if (cnt_q == LAST_SLOT) begin
					state_d = S_ADRAIN;
				end
			end
			S_ADRAIN: state_d = S_AWRITE;
			S_AWRITE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_FREAD: state_d = S_FWRITE;
			S_FWRITE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = addr_q;
		if (state_q == S_ALLOC) begin
			mem_rd_en = 1'b1;
		end else if (state_q == S_FREAD) begin
			mem_rd_en   = range_q;
			mem_rd_addr = slot_q;
		end
	end

	always_comb begin
		if (state_q == S_AWRITE) begin
			mem_wr_en   = commit;
			mem_wr_addr = best_q;
			mem_wr_data = alloc_cnt;
			res_status  = ST_ALLOCATED;
			res_vector  = {1'b0, base_q} + VEC_W'(best_q);
			res_count   = alloc_cnt;
		end else begin
			mem_wr_en   = commit && free_hit;
			mem_wr_addr = slot_q;
			mem_wr_data = mem_rd_data - CNT_W'(1);
			res_status  = free_hit ? ST_FREED : ST_IGNORED;
			res_vector  = vector_q;
			res_count   = free_hit ? mem_rd_data - CNT_W'(1) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= BASE_RESET;
			start_q     <= '0;
			scan_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			scan_s1 <= (state_q == S_ALLOC);
			if (cfg_wr_en) begin
				base_q <= cfg_wr_data;
			end
			if (commit && (state_q == S_AWRITE)) begin
				start_q <= best_next;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vector_q <= vector;
			slot_q   <= free_slot[SW-1:0];
			range_q  <= free_in_range;
			addr_q   <= start_q;
			cnt_q    <= '0;
		end else if (state_q == S_ALLOC) begin
			addr_q <= addr_next;
			cnt_q  <= cnt_q + SW'(1);
		end
		first_s1 <= (state_q == S_ALLOC) && (cnt_q == '0);
		slot_s1  <= addr_q;
		if (scan_s1 && (first_s1 || (mem_rd_data < best_cnt_q))) begin
			best_q     <= slot_s1;
			best_cnt_q <= mem_rd_data;
		end
		if (commit) begin
			status_q     <= res_status;
			vector_res_q <= res_vector;
			use_count_q  <= res_count;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign vector_res = vector_res_q;
	assign use_count  = use_count_q;

endmodule

`default_nettype wire

### rtl/least_used_vector_allocator_core.sv
// Channel   Dir  Handshake            Payload
// in        in   in_valid / in_stall  action, vector
// out       out  out_valid/ out_stall status, vector_res, use_count
// cfg       in   cfg_wr_en            cfg_wr_data (vector_base)
//
// Allocate reads each slot's count once from the count memory, then passes through a
// compare drain state and a write-back state that waits while the output is stalled.
// Free reads the count, then decrements it and writes it back.
// Reset is asynchronous; counts read as zero through per-entry valid bits.
// A stalled output holds the result; the next transaction is accepted meanwhile.
// Top level of the least-used vector allocator; depends on lva_pkg,
// lva_count_mem and lva_seq.
`timescale 1ns / 1ps
`default_nettype none

module least_used_vector_allocator_core #(
	parameter int VECTOR_COUNT = 128
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_wr_en,
	input  lva_pkg::base_t     cfg_wr_data,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire                action,
	input  lva_pkg::vec_t      vector,
	output logic               out_valid,
	input  wire                out_stall,
	output lva_pkg::status_t   status,
	output lva_pkg::vec_t      vector_res,
	output lva_pkg::cnt_t      use_count
);
	import lva_pkg::*;

	localparam int SW = $clog2(VECTOR_COUNT);

	logic          mem_rd_en;
	logic [SW-1:0] mem_rd_addr;
	logic          mem_wr_en;
	logic [SW-1:0] mem_wr_addr;
	cnt_t          mem_wr_data;
	cnt_t          mem_rd_data;

	lva_count_mem #(
		.DEPTH (VECTOR_COUNT),
		.AW    (SW)
	) u_count_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_data (mem_rd_data)
	);

	lva_seq #(
		.VECTOR_COUNT (VECTOR_COUNT),
		.SW           (SW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.vector      (vector),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.vector_res  (vector_res),
		.use_count   (use_count),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_data (mem_rd_data)
	);

`ifndef SYNTHESIS
	a_alloc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_ALLOCATED)) |-> (use_count != '0))
		else $error("allocated transaction with zero count");

	a_ignored_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_IGNORED)) |-> (use_count == '0))
		else $error("ignored free with nonzero count");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after accepted transaction");
`endif

endmodule

`default_nettype wire
